// ===== src/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Types and constants shared by the escape-time lanes, merge and top level.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int LANES    = 8;
  localparam int CNT_W    = 16;
  localparam int Q_W      = 32;
  localparam int PROD_W   = 64;
  localparam int COL_W    = 12;
  localparam int COLX_W   = 13;
  localparam int IM_W     = 26;
  localparam int WIDTH_W  = 13;
  localparam int STEP_W   = 26;
  localparam int USED_W   = 4;
  localparam int CFG_W    = 26;
  localparam int CFG_IDX_W = 2;
  localparam int RE_W     = COLX_W + STEP_W;

  // 2.5 in Q8.24
  localparam logic [Q_W-1:0] Q_TWO_P5 = 32'd41943040;
  // |z|^2 >= 4 in Q16.48 means any bit at or above 2^50 is set
  localparam int ESC_BIT = 50;

  localparam logic [WIDTH_W-1:0] WIDTH_RST = 13'd1024;
  localparam logic [STEP_W-1:0]  STEP_RST  = 26'd57400;
  localparam logic [CNT_W-1:0]   MAXIT_RST = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH = 2'd0,
    CFG_STEP  = 2'd1,
    CFG_MAXIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  typedef struct packed {
    logic             load;
    logic             mul;
    logic             add;
    logic             at_limit;
    logic [CNT_W-1:0] iter;
  } lane_ctrl_t;

  typedef struct packed {
    logic active;
    logic escape;
  } lane_stat_t;

  typedef logic [LANES-1:0][CNT_W-1:0] lane_cnt_t;

endpackage

// ===== src/mbe_in_if.sv =====
// ----------------------------------------------------------------------------
// mbe_in_if
// Input channel: one word per group of pixels on an image row.
// ----------------------------------------------------------------------------
interface mbe_in_if import mbe_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [COL_W-1:0]       column_start;
  logic signed [IM_W-1:0] imag_coord;

  modport source (output valid, output column_start, output imag_coord, input ready);
  modport sink   (input valid, input column_start, input imag_coord, output ready);

endinterface

// ===== src/mbe_out_if.sv =====
// ----------------------------------------------------------------------------
// mbe_out_if
// Output channel: escape counts of one pixel group and its used-lane count.
// ----------------------------------------------------------------------------
interface mbe_out_if import mbe_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  count_lane0;
  logic [CNT_W-1:0]  count_lane1;
  logic [CNT_W-1:0]  count_lane2;
  logic [CNT_W-1:0]  count_lane3;
  logic [CNT_W-1:0]  count_lane4;
  logic [CNT_W-1:0]  count_lane5;
  logic [CNT_W-1:0]  count_lane6;
  logic [CNT_W-1:0]  count_lane7;
  logic [USED_W-1:0] lanes_used;

  modport source (
    output valid, output count_lane0, output count_lane1, output count_lane2,
    output count_lane3, output count_lane4, output count_lane5, output count_lane6,
    output count_lane7, output lanes_used, input ready
  );
  modport sink (
    input valid, input count_lane0, input count_lane1, input count_lane2,
    input count_lane3, input count_lane4, input count_lane5, input count_lane6,
    input count_lane7, input lanes_used, output ready
  );

endinterface

// ===== src/mbe_lane.sv =====
// ----------------------------------------------------------------------------
// mbe_lane
// One escape-time core: z = z*z + c in Q8.24, squares registered in the multiply
// step, update and escape test in the cycle after.
// ----------------------------------------------------------------------------
module mbe_lane import mbe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctrl_t               ctrl_i,
  input  logic [COLX_W-1:0]        col_i,
  input  logic                     used_i,
  input  logic [STEP_W-1:0]        step_i,
  input  logic signed [Q_W-1:0]    cim_i,
  output lane_stat_t               stat_o,
  output logic [CNT_W-1:0]         count_o
);

  logic                     active_q;
  logic signed [Q_W-1:0]    v_q, w_q, cre_q;
  logic signed [PROD_W-1:0] vv_q, ww_q, vw_q;
  logic [CNT_W-1:0]         count_q;

  logic [RE_W-1:0]          re_prod;
  logic signed [PROD_W-1:0] diff;
  logic [PROD_W-1:0]        mag_sum;
  logic signed [Q_W-1:0]    nv, nw;
  logic                     esc, stop;

  assign re_prod = RE_W'(col_i) * RE_W'(step_i);
  assign diff    = vv_q - ww_q;
  assign mag_sum = $unsigned(vv_q) + $unsigned(ww_q);
  assign esc     = |mag_sum[PROD_W-1:ESC_BIT];
  assign nv      = diff[Q_W+23:24] + cre_q;
  assign nw      = vw_q[Q_W+22:23] + cim_i;
  assign stop    = esc | ctrl_i.at_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (ctrl_i.load) begin
      active_q <= used_i;
    end else if (ctrl_i.add && active_q && stop) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q     <= '0;
      w_q     <= '0;
      cre_q   <= re_prod[Q_W-1:0] - Q_TWO_P5;
      count_q <= '0;
    end
    if (ctrl_i.mul) begin
      vv_q <= v_q * v_q;
      ww_q <= w_q * w_q;
      vw_q <= v_q * w_q;
    end
    if (ctrl_i.add && active_q) begin
      if (stop) begin
        count_q <= ctrl_i.iter;
      end else begin
        v_q <= nv;
        w_q <= nw;
      end
    end
  end

  assign stat_o.active = active_q;
  assign stat_o.escape = esc;
  assign count_o       = count_q;

endmodule

// ===== src/mbe_merge.sv =====
// ----------------------------------------------------------------------------
// mbe_merge
// Collect the lane counts into one output word, count the used lanes and
// hold the word until the sink takes it.
// ----------------------------------------------------------------------------
module mbe_merge import mbe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lane_cnt_t        counts_i,
  input  logic [LANES-1:0] used_i,
  output logic             ready_o,
  mbe_out_if.source        out_o
);

  logic              valid_q;
  lane_cnt_t         cnt_q;
  logic [USED_W-1:0] used_q;

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      cnt_q  <= counts_i;
      used_q <= USED_W'($countones(used_i));
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.count_lane0 = cnt_q[0];
  assign out_o.count_lane1 = cnt_q[1];
  assign out_o.count_lane2 = cnt_q[2];
  assign out_o.count_lane3 = cnt_q[3];
  assign out_o.count_lane4 = cnt_q[4];
  assign out_o.count_lane5 = cnt_q[5];
  assign out_o.count_lane6 = cnt_q[6];
  assign out_o.count_lane7 = cnt_q[7];
  assign out_o.lanes_used  = used_q;

endmodule

// ===== src/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time counts for groups of eight pixels, one core per pixel.
// Steps: accept in IDLE, load in SETUP, then square and update passes until all
// lanes stop or the limit is hit, then DONE hands the word to the merge. A new
// group is accepted only in IDLE, once the last one is handed on to the merge.
// Reset: asynchronous, active low; width 1024, step 57400, limit 256.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  mbe_in_if.sink               in_i,
  mbe_out_if.source            out_o
);

  state_e               state_q, state_d;
  logic [WIDTH_W-1:0]   width_q;
  logic [STEP_W-1:0]    step_q;
  logic [CNT_W-1:0]     maxit_q;
  logic [CNT_W-1:0]     iter_q;
  logic [COL_W-1:0]     col0_q;
  logic signed [IM_W-1:0] cim_q;

  lane_ctrl_t           ctrl;
  lane_stat_t [LANES-1:0] stat;
  lane_cnt_t            counts;
  logic [LANES-1:0]     used;
  logic [LANES-1:0]     lane_stop;
  logic [LANES-1:0]     lane_active;
  logic [COLX_W-1:0]    col [LANES];
  logic                 merge_ready;
  logic                 push;
  logic                 all_stop;
  logic                 in_acc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign push       = (state_q == ST_DONE) && merge_ready;
  assign all_stop   = &lane_stop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RST;
      step_q  <= STEP_RST;
      maxit_q <= MAXIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH: width_q <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_STEP:  step_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_MAXIT: maxit_q <= cfg_wdata_i[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   state_d = (all_stop || ctrl.at_limit) ? ST_DONE : ST_MUL;
      ST_DONE:  if (merge_ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SETUP) begin
        iter_q <= '0;
      end else if (state_q == ST_ADD && state_d == ST_MUL) begin
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col0_q <= in_i.column_start;
      cim_q  <= in_i.imag_coord;
    end
  end

  assign ctrl.load     = (state_q == ST_SETUP);
  assign ctrl.mul      = (state_q == ST_MUL);
  assign ctrl.add      = (state_q == ST_ADD);
  assign ctrl.at_limit = (iter_q == maxit_q);
  assign ctrl.iter     = iter_q;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    assign col[k]         = COLX_W'(col0_q) + COLX_W'(k);
    assign used[k]        = (col[k] < width_q) && (32'(col[k]) < 32'(MAX_WIDTH));
    assign lane_stop[k]   = !stat[k].active || stat[k].escape;
    assign lane_active[k] = stat[k].active;

    mbe_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .col_i   (col[k]),
      .used_i  (used[k]),
      .step_i  (step_q),
      .cim_i   (Q_W'(cim_q)),
      .stat_o  (stat[k]),
      .count_o (counts[k])
    );
  end

  mbe_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .counts_i (counts),
    .used_i   (used),
    .ready_o  (merge_ready),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  a_done_lanes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> lane_active == '0)
    else $error("lane still active at handoff");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD |-> iter_q <= maxit_q)
    else $error("iteration count past limit");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_o.valid)
    else $error("handed word not shown at output");

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_SETUP && !in_i.ready)
    else $error("accepted word did not start setup");
`endif

endmodule
